/* rtl/gqg_pkg.sv */
package gqg_pkg;

    // opcodes carried in the input tuser
    localparam logic [1:0] OP_WRITE   = 2'd0;
    localparam logic [1:0] OP_START   = 2'd1;
    localparam logic [1:0] OP_DRAW    = 2'd2;
    localparam logic [1:0] OP_MEASURE = 2'd3;

    // result kind carried in the output tuser
    localparam logic KIND_VERTEX  = 1'b0;
    localparam logic KIND_MEASURE = 1'b1;

    // configuration register indexes
    localparam logic [1:0] CFG_X_SCALE = 2'd0;
    localparam logic [1:0] CFG_Y_SCALE = 2'd1;
    localparam logic [1:0] CFG_COLOR   = 2'd2;

    localparam logic [15:0] X_SCALE_RST = 16'd256;
    localparam logic [15:0] Y_SCALE_RST = 16'd256;
    localparam logic [31:0] COLOR_RST   = 32'hFFFF_FFFF;

    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CASE_FOLD    = 8'h20;

    localparam logic [23:0] SUM_MAX    = 24'hFF_FFFF;
    localparam logic [15:0] RESULT_MAX = 16'hFFFF;
    localparam logic [7:0]  ROUND_HALF = 8'h80;

    localparam int IN_DATA_W  = 96;
    localparam int OUT_DATA_W = 112;

    typedef struct packed {
        logic [7:0] adv;
        logic [7:0] oy;
        logic [7:0] ox;
        logic [7:0] h;
        logic [7:0] w;
        logic [7:0] v;
        logic [7:0] u;
    } t_glyph;

    localparam int GLYPH_W = $bits(t_glyph);

    typedef struct packed {
        logic [15:0] x_scale;
        logic [15:0] y_scale;
        logic [31:0] color;
    } t_cfg;

    // one finished request: a whole quad or one measurement
    typedef struct packed {
        logic        kind;
        logic [15:0] x1;
        logic [15:0] x2;
        logic [15:0] y1;
        logic [15:0] y2;
        logic [7:0]  u1;
        logic [7:0]  u2;
        logic [7:0]  v1;
        logic [7:0]  v2;
        logic [31:0] color;
        logic [15:0] str_w;
        logic [15:0] str_h;
    } t_quad;

endpackage

/* rtl/gqg_ram.sv */
module gqg_ram #(
    parameter int WIDTH = 56,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/gqg_core.sv */
module gqg_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  logic [1:0]            i_op,
    input  logic                  i_last,
    input  logic [15:0]           i_origin_x,
    input  logic [15:0]           i_origin_y,
    input  logic                  i_hit,
    input  gqg_pkg::t_glyph       i_glyph,
    input  gqg_pkg::t_cfg         i_cfg,
    input  logic [7:0]            i_tallest,
    input  logic                  i_out_free,
    output logic                  o_ready,
    output logic                  o_push,
    output gqg_pkg::t_quad        o_quad
);

    logic            r_vld;
    logic [1:0]      r_op;
    logic            r_last;
    logic [15:0]     r_origin_x;
    logic [15:0]     r_origin_y;
    logic            r_hit;

    logic [15:0]     r_pen_x;
    logic [15:0]     r_pen_y;
    logic [15:0]     r_pen_off;
    logic [23:0]     r_sum;
    logic [15:0]     n_pen_x;
    logic [15:0]     n_pen_y;
    logic [15:0]     n_pen_off;
    logic [23:0]     n_sum;

    gqg_pkg::t_glyph g;
    logic            needs_out;
    logic            adv;
    logic [23:0]     w_prod;
    logic [23:0]     h_prod;
    logic [23:0]     a_prod;
    logic [15:0]     ox16;
    logic [15:0]     oy16;
    logic [15:0]     x1;
    logic [15:0]     y1;
    logic [7:0]      add;
    logic [24:0]     sum_raw;
    logic [23:0]     sum_sat;
    logic [39:0]     mw_prod;
    logic [24:0]     mh_prod;
    logic [31:0]     mw_q;
    logic [16:0]     mh_q;

    // a code that was never written or lies past the table reads as zero
    assign g = r_hit ? i_glyph : '0;

    assign needs_out = (r_op == gqg_pkg::OP_DRAW) ||
                       ((r_op == gqg_pkg::OP_MEASURE) && r_last);
    assign adv      = r_vld && (!needs_out || i_out_free);
    assign o_push   = r_vld && needs_out && i_out_free;
    assign o_ready  = !r_vld || adv;

    assign w_prod = {16'b0, g.w}   * {8'b0, i_cfg.x_scale};
    assign h_prod = {16'b0, g.h}   * {8'b0, i_cfg.y_scale};
    assign a_prod = {16'b0, g.adv} * {8'b0, i_cfg.x_scale};

    assign ox16 = {{8{g.ox[7]}}, g.ox};
    assign oy16 = {{8{g.oy[7]}}, g.oy};
    assign x1   = r_pen_x + ox16 + r_pen_off;
    assign y1   = r_pen_y + {8'b0, g.h} + oy16;

    assign add     = r_last ? g.w : g.adv;
    assign sum_raw = {1'b0, r_sum} + {17'b0, add};
    assign sum_sat = sum_raw[24] ? gqg_pkg::SUM_MAX : sum_raw[23:0];

    assign mw_prod = {16'b0, sum_sat} * {24'b0, i_cfg.x_scale} +
                     {32'b0, gqg_pkg::ROUND_HALF};
    assign mh_prod = {17'b0, i_tallest} * {9'b0, i_cfg.y_scale} +
                     {17'b0, gqg_pkg::ROUND_HALF};
    assign mw_q    = mw_prod[39:8];
    assign mh_q    = mh_prod[24:8];

    always_comb begin
        o_quad = '0;
        if (r_op == gqg_pkg::OP_MEASURE) begin
            o_quad.kind  = gqg_pkg::KIND_MEASURE;
            o_quad.str_w = (mw_q[31:16] != 16'b0) ? gqg_pkg::RESULT_MAX : mw_q[15:0];
            o_quad.str_h = mh_q[16] ? gqg_pkg::RESULT_MAX : mh_q[15:0];
        end else begin
            o_quad.kind  = gqg_pkg::KIND_VERTEX;
            o_quad.x1    = x1;
            o_quad.x2    = x1 + w_prod[23:8];
            o_quad.y1    = y1;
            o_quad.y2    = y1 - h_prod[23:8];
            o_quad.u1    = g.u;
            o_quad.u2    = g.u + g.w;
            o_quad.v1    = g.v;
            o_quad.v2    = g.v + g.h;
            o_quad.color = i_cfg.color;
        end
    end

    always_comb begin
        n_pen_x   = r_pen_x;
        n_pen_y   = r_pen_y;
        n_pen_off = r_pen_off;
        n_sum     = r_sum;
        if (adv) begin
            unique case (r_op)
                gqg_pkg::OP_START: begin
                    n_pen_x   = r_origin_x;
                    n_pen_y   = r_origin_y;
                    n_pen_off = '0;
                end
                gqg_pkg::OP_DRAW: begin
                    n_pen_off = r_pen_off + a_prod[23:8];
                end
                gqg_pkg::OP_MEASURE: begin
                    n_sum = r_last ? '0 : sum_sat;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= 1'b0;
            r_pen_x   <= '0;
            r_pen_y   <= '0;
            r_pen_off <= '0;
            r_sum     <= '0;
        end else begin
            if (i_accept) begin
                r_vld <= 1'b1;
            end else if (adv) begin
                r_vld <= 1'b0;
            end
            r_pen_x   <= n_pen_x;
            r_pen_y   <= n_pen_y;
            r_pen_off <= n_pen_off;
            r_sum     <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_op       <= i_op;
            r_last     <= i_last;
            r_origin_x <= i_origin_x;
            r_origin_y <= i_origin_y;
            r_hit      <= i_hit;
        end
    end

endmodule

/* rtl/gqg_emit.sv */
module gqg_emit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_push,
    input  gqg_pkg::t_quad                   i_quad,
    output logic                             o_free,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [gqg_pkg::OUT_DATA_W-1:0]   o_m_tdata,
    output logic                             o_m_tuser,
    output logic                             o_m_tlast
);

    gqg_pkg::t_quad r_q;
    logic           r_vld;
    logic [1:0]     r_cnt;
    logic           last;
    logic           done;
    logic [15:0]    vx;
    logic [15:0]    vy;
    logic [7:0]     tu;
    logic [7:0]     tv;

    assign last   = (r_q.kind == gqg_pkg::KIND_MEASURE) || (r_cnt == 2'd3);
    assign done   = r_vld && i_m_tready && last;
    assign o_free = !r_vld || done;

    // corner order: top-left, top-right, bottom-right, bottom-left
    always_comb begin
        unique case (r_cnt)
            2'd0: begin vx = r_q.x1; vy = r_q.y2; tu = r_q.u1; tv = r_q.v1; end
            2'd1: begin vx = r_q.x2; vy = r_q.y2; tu = r_q.u2; tv = r_q.v1; end
            2'd2: begin vx = r_q.x2; vy = r_q.y1; tu = r_q.u2; tv = r_q.v2; end
            default: begin vx = r_q.x1; vy = r_q.y1; tu = r_q.u1; tv = r_q.v2; end
        endcase
    end

    assign o_m_tvalid = r_vld;
    assign o_m_tuser  = r_q.kind;
    assign o_m_tlast  = last;
    assign o_m_tdata  = {r_q.str_h, r_q.str_w, r_q.color, tv, tu, vy, vx};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_vld <= 1'b1;
                r_cnt <= '0;
            end else if (done) begin
                r_vld <= 1'b0;
            end else if (r_vld && i_m_tready) begin
                r_cnt <= r_cnt + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q <= i_quad;
        end
    end

endmodule

/* rtl/glyph_quad_generator.sv */
// Glyph quad generator.
// Input stream (s side): one request per transfer. tuser is the opcode
// (write glyph, start string, draw char, measure char); tlast marks the last
// character of a measured string. Write and start requests give no output.
// Output stream (m side): a draw gives four vertex transfers, tlast on the
// fourth; a measure with tlast set gives one measurement transfer.
// A request accepted from the input is held in the lookup/compute register
// and then registered into the output register once that register is free.
// Throughput: one request per cycle for writes, starts and unmarked measures
// while nothing waits on the output; a draw holds the output register until
// its fourth vertex is taken, and the next draw is pushed as that vertex goes.
// Reset (synchronous, active low) empties both stages, clears pen state,
// width sum and tallest height, restores the scale and color registers, and
// marks every glyph entry unwritten so it reads as zero. No clearing pass.
// When the receiver stalls the output holds; the compute stage keeps one
// request waiting behind it and then tready drops.
// Configuration writes (x_scale, y_scale, draw_color) are taken any cycle.
module glyph_quad_generator #(
    parameter int GLYPH_COUNT = 256
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [1:0]                      i_cfg_idx,
    input  logic [31:0]                     i_cfg_data,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // char_code, glyph_u, glyph_v, glyph_w, glyph_h, offset_x, offset_y,
    // advance, origin_x, origin_y
    input  logic [gqg_pkg::IN_DATA_W-1:0]   i_s_tdata,
    // opcode
    input  logic [1:0]                      i_s_tuser,
    input  logic                            i_s_tlast,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // vertex_x, vertex_y, tex_u, tex_v, vertex_color, string_width,
    // string_height
    output logic [gqg_pkg::OUT_DATA_W-1:0]  o_m_tdata,
    // result_kind
    output logic                            o_m_tuser,
    output logic                            o_m_tlast
);

    localparam int AW = $clog2(GLYPH_COUNT);

    gqg_pkg::t_cfg   r_cfg;
    logic [7:0]      r_tallest;
    logic [GLYPH_COUNT-1:0] r_gvalid;

    logic            accept;
    logic [7:0]      code;
    logic [7:0]      fold;
    logic            code_ok;
    logic            fold_ok;
    logic            wr;
    logic            hit;
    gqg_pkg::t_glyph wglyph;
    gqg_pkg::t_glyph rglyph;
    logic            out_free;
    logic            push;
    gqg_pkg::t_quad  quad;

    assign accept = i_s_tvalid && o_s_tready;
    assign code   = i_s_tdata[7:0];
    assign fold   = (code >= gqg_pkg::CHAR_LOWER_A && code <= gqg_pkg::CHAR_LOWER_Z) ?
                    code - gqg_pkg::CASE_FOLD : code;
    assign code_ok = {1'b0, code} < 9'(GLYPH_COUNT);
    assign fold_ok = {1'b0, fold} < 9'(GLYPH_COUNT);

    assign wglyph.u   = i_s_tdata[15:8];
    assign wglyph.v   = i_s_tdata[23:16];
    assign wglyph.w   = i_s_tdata[31:24];
    assign wglyph.h   = i_s_tdata[39:32];
    assign wglyph.ox  = i_s_tdata[47:40];
    assign wglyph.oy  = i_s_tdata[55:48];
    assign wglyph.adv = i_s_tdata[63:56];

    assign wr  = accept && (i_s_tuser == gqg_pkg::OP_WRITE) && code_ok;
    assign hit = fold_ok && r_gvalid[fold[AW-1:0]];

    gqg_ram #(
        .WIDTH (gqg_pkg::GLYPH_W),
        .DEPTH (GLYPH_COUNT)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (wr),
        .i_waddr (code[AW-1:0]),
        .i_wdata (wglyph),
        .i_re    (accept),
        .i_raddr (fold[AW-1:0]),
        .o_rdata (rglyph)
    );

    gqg_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_op       (i_s_tuser),
        .i_last     (i_s_tlast),
        .i_origin_x (i_s_tdata[79:64]),
        .i_origin_y (i_s_tdata[95:80]),
        .i_hit      (hit),
        .i_glyph    (rglyph),
        .i_cfg      (r_cfg),
        .i_tallest  (r_tallest),
        .i_out_free (out_free),
        .o_ready    (o_s_tready),
        .o_push     (push),
        .o_quad     (quad)
    );

    gqg_emit u_emit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_quad     (quad),
        .o_free     (out_free),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.x_scale <= gqg_pkg::X_SCALE_RST;
            r_cfg.y_scale <= gqg_pkg::Y_SCALE_RST;
            r_cfg.color   <= gqg_pkg::COLOR_RST;
            r_tallest     <= '0;
            r_gvalid      <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    gqg_pkg::CFG_X_SCALE: r_cfg.x_scale <= i_cfg_data[15:0];
                    gqg_pkg::CFG_Y_SCALE: r_cfg.y_scale <= i_cfg_data[15:0];
                    gqg_pkg::CFG_COLOR:   r_cfg.color   <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (wr) begin
                r_gvalid[code[AW-1:0]] <= 1'b1;
                if (wglyph.h > r_tallest) begin
                    r_tallest <= wglyph.h;
                end
            end
        end
    end

endmodule

/* dv/tb_top.sv */
module tb_top;

    localparam int GLYPH_SLOTS  = 256;
    localparam int RANDOM_ITEMS = 250;
    localparam int PHASES       = 5;
    localparam int DRAIN_CYCLES = 6;
    localparam int LONG_HOLD    = 150;
    localparam int STALL_LIMIT  = 3000;
    localparam int MAX_PRINTS   = 100;

    typedef struct {
        logic [1:0]      op;
        logic [7:0]      code;
        gqg_pkg::t_glyph g;
        logic [15:0]     org_x;
        logic [15:0]     org_y;
        logic            last;
    } t_glyph_req;

    typedef struct packed {
        logic        kind;
        logic [15:0] x;
        logic [15:0] y;
        logic [7:0]  u;
        logic [7:0]  v;
        logic [31:0] color;
        logic [15:0] sw;
        logic [15:0] sh;
        logic        last;
    } t_quad_res;

    // one line of the directed script: a request, or a new set of registers
    typedef struct {
        bit          is_cfg;
        logic [15:0] xs;
        logic [15:0] ys;
        logic [31:0] rgba;
        t_glyph_req  req;
        bit          pinned;
        t_quad_res   want;
    } t_script_row;

    logic                           i_clk      = 1'b0;
    logic                           i_rst_n    = 1'b0;
    logic                           i_cfg_we   = 1'b0;
    logic [1:0]                     i_cfg_idx  = '0;
    logic [31:0]                    i_cfg_data = '0;
    logic                           i_s_tvalid = 1'b0;
    logic                           o_s_tready;
    logic [gqg_pkg::IN_DATA_W-1:0]  i_s_tdata  = '0;
    logic [1:0]                     i_s_tuser  = '0;
    logic                           i_s_tlast  = 1'b0;
    logic                           o_m_tvalid;
    logic                           i_m_tready = 1'b0;
    logic [gqg_pkg::OUT_DATA_W-1:0] o_m_tdata;
    logic                           o_m_tuser;
    logic                           o_m_tlast;

    glyph_quad_generator dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    always #10 i_clk = ~i_clk;

    // shadow of the block state
    gqg_pkg::t_glyph glyph_mem [GLYPH_SLOTS];
    logic [7:0]      max_h;
    logic [15:0]     pen_adv;
    logic [15:0]     pen_x;
    logic [15:0]     pen_y;
    logic [23:0]     run_width;
    logic [15:0]     cfg_xs;
    logic [15:0]     cfg_ys;
    logic [31:0]     cfg_rgba;

    t_quad_res outputs_due [$];
    int        err_count  = 0;
    int        burst_left = 0;
    bit        steady     = 1'b0;
    bit        hold_req   = 1'b0;

    task automatic report_mismatch(input string what, input t_quad_res got,
                                   input t_quad_res want);
        err_count++;
        if (err_count <= MAX_PRINTS)
            $display("ERROR %s: got %h, want %h", what, got, want);
    endtask

    function automatic gqg_pkg::t_glyph fold_lookup(input logic [7:0] code);
        logic [7:0] c;
        c = code;
        if (c >= gqg_pkg::CHAR_LOWER_A && c <= gqg_pkg::CHAR_LOWER_Z)
            c = c - gqg_pkg::CASE_FOLD;
        return glyph_mem[c];
    endfunction

    function automatic logic [15:0] round_sat(input logic [40:0] prod);
        logic [40:0] t;
        t = prod + gqg_pkg::ROUND_HALF;
        return (t[40:8] > gqg_pkg::RESULT_MAX) ? gqg_pkg::RESULT_MAX : t[23:8];
    endfunction

    task automatic push_vertex(input logic [15:0] x, input logic [15:0] y,
                               input logic [7:0] u, input logic [7:0] v,
                               input logic last);
        t_quad_res q;
        q = '0;
        q.kind  = gqg_pkg::KIND_VERTEX;
        q.x     = x;
        q.y     = y;
        q.u     = u;
        q.v     = v;
        q.color = cfg_rgba;
        q.last  = last;
        outputs_due.push_back(q);
    endtask

    // advance the shadow state by one request; queue its outputs when emit is set
    task automatic predict_glyph_output(input t_glyph_req r, input bit emit);
        gqg_pkg::t_glyph g;
        logic [23:0]     pw, ph, pa;
        logic [15:0]     x1, x2, y1, y2;
        logic [7:0]      u2, v2;
        logic [24:0]     sum;
        t_quad_res       q;
        case (r.op)
            gqg_pkg::OP_WRITE: begin
                glyph_mem[r.code] = r.g;
                if (r.g.h > max_h)
                    max_h = r.g.h;
            end
            gqg_pkg::OP_START: begin
                pen_x   = r.org_x;
                pen_y   = r.org_y;
                pen_adv = '0;
            end
            gqg_pkg::OP_DRAW: begin
                g  = fold_lookup(r.code);
                pw = g.w * cfg_xs;
                ph = g.h * cfg_ys;
                pa = g.adv * cfg_xs;
                x1 = pen_x + {{8{g.ox[7]}}, g.ox} + pen_adv;
                x2 = x1 + pw[23:8];
                y1 = pen_y + {8'd0, g.h} + {{8{g.oy[7]}}, g.oy};
                y2 = y1 - ph[23:8];
                u2 = g.u + g.w;
                v2 = g.v + g.h;
                if (emit) begin
                    push_vertex(x1, y2, g.u, g.v, 1'b0);
                    push_vertex(x2, y2, u2, g.v, 1'b0);
                    push_vertex(x2, y1, u2, v2, 1'b0);
                    push_vertex(x1, y1, g.u, v2, 1'b1);
                end
                pen_adv = pen_adv + pa[23:8];
            end
            default: begin
                g   = fold_lookup(r.code);
                sum = run_width + (r.last ? g.w : g.adv);
                if (sum > gqg_pkg::SUM_MAX)
                    sum = gqg_pkg::SUM_MAX;
                if (!r.last) begin
                    run_width = sum[23:0];
                end else begin
                    run_width = '0;
                    q         = '0;
                    q.kind    = gqg_pkg::KIND_MEASURE;
                    q.sw      = round_sat(sum * cfg_xs);
                    q.sh      = round_sat(max_h * cfg_ys);
                    q.last    = 1'b1;
                    if (emit)
                        outputs_due.push_back(q);
                end
            end
        endcase
    endtask

    // offer one request, honoring the burst/gap pattern, and predict it on accept
    task automatic send_req(input t_glyph_req r, input bit emit);
        int gap;
        if (burst_left == 0) begin
            gap = steady ? 0 : $urandom_range(0, 9);
            if (gap > 3 && $urandom_range(0, 1))
                gap = 0;
            if (gap > 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {r.org_y, r.org_x, r.g.adv, r.g.oy, r.g.ox, r.g.h, r.g.w,
                       r.g.v, r.g.u, r.code};
        i_s_tuser  <= r.op;
        i_s_tlast  <= r.last;
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
        predict_glyph_output(r, emit);
    endtask

    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        burst_left = 0;
        while (outputs_due.size() != 0)
            @(posedge i_clk);
        // a write or start may still sit in the pipe with nothing queued
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_settings(input logic [15:0] xs, input logic [15:0] ys,
                                 input logic [31:0] rgba);
        wait_drained();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= gqg_pkg::CFG_X_SCALE;
        i_cfg_data <= {16'($urandom), xs};
        @(posedge i_clk);
        i_cfg_idx  <= gqg_pkg::CFG_Y_SCALE;
        i_cfg_data <= {16'($urandom), ys};
        @(posedge i_clk);
        i_cfg_idx  <= gqg_pkg::CFG_COLOR;
        i_cfg_data <= rgba;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        cfg_xs   = xs;
        cfg_ys   = ys;
        cfg_rgba = rgba;
    endtask

    function automatic logic [7:0] pick_code();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 60)
            return 8'h41 + 8'($urandom_range(0, 25));
        else if (sel < 80)
            return gqg_pkg::CHAR_LOWER_A + 8'($urandom_range(0, 25));
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic t_glyph_req rand_req();
        t_glyph_req  r;
        logic [63:0] bits;
        bits    = {$urandom, $urandom};
        r.op    = gqg_pkg::OP_DRAW;
        r.code  = pick_code();
        r.g     = bits[55:0];
        r.org_x = 16'($urandom);
        r.org_y = 16'($urandom);
        r.last  = 1'($urandom_range(0, 1));
        return r;
    endfunction

    function automatic logic [15:0] pick_scale();
        case ($urandom_range(0, 5))
            0:       return 16'd256;
            1:       return 16'd0;
            2:       return 16'hFFFF;
            3:       return 16'($urandom_range(1, 1023));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic run_random(input int quota);
        int         sent, mix, run, k;
        t_glyph_req r;
        sent = 0;
        while (sent < quota) begin
            mix = $urandom_range(0, 99);
            run = $urandom_range(1, 6);
            for (k = 0; k < run; k++) begin
                r = rand_req();
                if (mix < 20) begin
                    r.op = gqg_pkg::OP_WRITE;
                end else if (mix < 30) begin
                    r.op = gqg_pkg::OP_START;
                end else if (mix < 65) begin
                    r.op = gqg_pkg::OP_DRAW;
                end else begin
                    r.op = gqg_pkg::OP_MEASURE;
                    // mostly a string closed on its final char, some broken runs
                    if (mix < 92)
                        r.last = (k == run - 1);
                end
                send_req(r, 1'b1);
                sent++;
            end
        end
    endtask

    function automatic t_script_row req_row(input logic [1:0] op, input logic [7:0] code,
                                            input logic last);
        t_script_row s;
        s         = '{default: '0};
        s.req.op   = op;
        s.req.code = code;
        s.req.last = last;
        return s;
    endfunction

    function automatic t_script_row wr_row(input logic [7:0] code, input logic [7:0] u,
                                           input logic [7:0] v, input logic [7:0] w,
                                           input logic [7:0] h, input logic [7:0] ox,
                                           input logic [7:0] oy, input logic [7:0] adv);
        t_script_row s;
        s = req_row(gqg_pkg::OP_WRITE, code, 1'b0);
        s.req.g = '{adv: adv, oy: oy, ox: ox, h: h, w: w, v: v, u: u};
        return s;
    endfunction

    function automatic t_script_row st_row(input logic [15:0] x, input logic [15:0] y);
        t_script_row s;
        s = req_row(gqg_pkg::OP_START, 8'h00, 1'b0);
        s.req.org_x = x;
        s.req.org_y = y;
        return s;
    endfunction

    function automatic t_script_row cfg_row(input logic [15:0] xs, input logic [15:0] ys,
                                            input logic [31:0] rgba);
        t_script_row s;
        s        = '{default: '0};
        s.is_cfg = 1'b1;
        s.xs     = xs;
        s.ys     = ys;
        s.rgba   = rgba;
        return s;
    endfunction

    function automatic t_script_row pin_meas(input logic [7:0] code, input logic [15:0] sw,
                                             input logic [15:0] sh);
        t_script_row s;
        s = req_row(gqg_pkg::OP_MEASURE, code, 1'b1);
        s.pinned    = 1'b1;
        s.want      = '0;
        s.want.kind = gqg_pkg::KIND_MEASURE;
        s.want.sw   = sw;
        s.want.sh   = sh;
        s.want.last = 1'b1;
        return s;
    endfunction

    // a draw of an empty glyph at the origin: four identical corners
    function automatic t_script_row pin_empty_quad(input logic [7:0] code,
                                                   input logic [31:0] rgba);
        t_script_row s;
        s = req_row(gqg_pkg::OP_DRAW, code, 1'b0);
        s.pinned     = 1'b1;
        s.want       = '0;
        s.want.kind  = gqg_pkg::KIND_VERTEX;
        s.want.color = rgba;
        return s;
    endfunction

    task automatic push_pinned(input t_script_row s);
        t_quad_res q;
        int        k;
        q = s.want;
        if (s.req.op == gqg_pkg::OP_DRAW) begin
            for (k = 0; k < 4; k++) begin
                q.last = (k == 3);
                outputs_due.push_back(q);
            end
        end else begin
            outputs_due.push_back(q);
        end
    endtask

    // receiver: random stall pattern, redrawn each time its run ends
    initial begin : rx_side
        int mode, left, tick;
        mode = 0;
        left = 0;
        tick = 0;
        forever begin
            @(posedge i_clk);
            tick++;
            if (hold_req) begin
                hold_req = 1'b0;
                i_m_tready <= 1'b0;
                repeat (LONG_HOLD - 1) @(posedge i_clk);
            end else begin
                if (left == 0) begin
                    mode = $urandom_range(0, 3);
                    left = $urandom_range(8, 60);
                end
                left--;
                case (mode)
                    0:       i_m_tready <= 1'b1;
                    1:       i_m_tready <= 1'($urandom_range(0, 1));
                    2:       i_m_tready <= ($urandom_range(0, 3) == 0);
                    default: i_m_tready <= (tick % 3 != 0);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin : out_check
        t_quad_res got, want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.kind  = o_m_tuser;
            got.x     = o_m_tdata[15:0];
            got.y     = o_m_tdata[31:16];
            got.u     = o_m_tdata[39:32];
            got.v     = o_m_tdata[47:40];
            got.color = o_m_tdata[79:48];
            got.sw    = o_m_tdata[95:80];
            got.sh    = o_m_tdata[111:96];
            got.last  = o_m_tlast;
            if (outputs_due.size() == 0) begin
                report_mismatch("unexpected result", got, '0);
            end else begin
                want = outputs_due.pop_front();
                if (got !== want)
                    report_mismatch("result mismatch", got, want);
            end
        end
    end

    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < STALL_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
                idle = 0;
            else
                idle++;
        end
        $display("tb_top NOT OK");
        $finish;
    end

    initial begin : stimulus
        t_script_row script [$];
        int          ph;
        foreach (glyph_mem[i])
            glyph_mem[i] = '0;
        max_h     = '0;
        pen_adv   = '0;
        pen_x     = '0;
        pen_y     = '0;
        run_width = '0;
        cfg_xs    = gqg_pkg::X_SCALE_RST;
        cfg_ys    = gqg_pkg::Y_SCALE_RST;
        cfg_rgba  = gqg_pkg::COLOR_RST;

        // after reset: empty table, unit scales, white
        script.push_back(pin_meas(8'h41, 16'd0, 16'd0));
        script.push_back(pin_empty_quad(8'h41, 32'hFFFF_FFFF));
        script.push_back(wr_row(8'h41, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h80, 8'h7F, 8'hFF));
        script.push_back(wr_row(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        script.push_back(wr_row(8'hFF, 8'h00, 8'h00, 8'h01, 8'h01, 8'h7F, 8'h80, 8'h00));
        // lowercase slot is stored but never read back by a lookup
        script.push_back(wr_row(8'h61, 8'h12, 8'h34, 8'h03, 8'hC8, 8'h05, 8'hFB, 8'h07));
        script.push_back(st_row(16'h7FFF, 16'h8000));
        script.push_back(req_row(gqg_pkg::OP_DRAW, 8'h61, 1'b1));
        script.push_back(req_row(gqg_pkg::OP_DRAW, 8'h41, 1'b0));
        script.push_back(req_row(gqg_pkg::OP_DRAW, 8'hFF, 1'b0));
        script.push_back(req_row(gqg_pkg::OP_DRAW, 8'h00, 1'b1));
        script.push_back(req_row(gqg_pkg::OP_DRAW, 8'h7A, 1'b0));
        script.push_back(req_row(gqg_pkg::OP_DRAW, 8'h60, 1'b0));
        script.push_back(req_row(gqg_pkg::OP_MEASURE, 8'h41, 1'b0));
        script.push_back(req_row(gqg_pkg::OP_MEASURE, 8'hFF, 1'b0));
        script.push_back(req_row(gqg_pkg::OP_MEASURE, 8'h61, 1'b1));
        script.push_back(pin_meas(8'h00, 16'd0, 16'd255));
        script.push_back(st_row(16'h8000, 16'h7FFF));
        script.push_back(cfg_row(16'hFFFF, 16'hFFFF, 32'h0000_0000));
        script.push_back(req_row(gqg_pkg::OP_DRAW, 8'h41, 1'b0));
        // 255 at the largest scale rounds to just under the ceiling
        script.push_back(pin_meas(8'h41, 16'hFEFF, 16'hFEFF));
        script.push_back(req_row(gqg_pkg::OP_DRAW, 8'hFF, 1'b1));
        script.push_back(cfg_row(16'h0000, 16'h0000, 32'h1234_5678));
        script.push_back(req_row(gqg_pkg::OP_DRAW, 8'h41, 1'b0));
        script.push_back(req_row(gqg_pkg::OP_MEASURE, 8'h41, 1'b0));
        script.push_back(pin_meas(8'h41, 16'd0, 16'd0));

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script[i]) begin
            if (script[i].is_cfg) begin
                load_settings(script[i].xs, script[i].ys, script[i].rgba);
            end else begin
                send_req(script[i].req, !script[i].pinned);
                if (script[i].pinned)
                    push_pinned(script[i]);
            end
        end

        for (ph = 0; ph < PHASES; ph++) begin
            if (ph == 0)
                load_settings(16'd256, 16'd256, $urandom);
            else
                load_settings(pick_scale(), pick_scale(), $urandom);
            // one phase backs up the output and keeps the input side busy
            if (ph == 2) begin
                hold_req = 1'b1;
                steady   = 1'b1;
            end
            run_random(RANDOM_ITEMS / PHASES);
            steady = 1'b0;
        end

        i_s_tvalid <= 1'b0;
        while (outputs_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES * 2) @(posedge i_clk);
        if (err_count == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

/* files.f */
rtl/gqg_pkg.sv
rtl/gqg_ram.sv
rtl/gqg_core.sv
rtl/gqg_emit.sv
rtl/glyph_quad_generator.sv
dv/tb_top.sv
